@@ src/bsa_pkg.sv @@
`timescale 1ns / 1ps

package bsa_pkg;

  // Field widths of the request, response and configuration port
  localparam int OP_W       = 1;
  localparam int SLOT_W     = 10;
  localparam int ADDR_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int STRIDE_W   = 16;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Compare width that holds any slot index or count (up to 65536)
  localparam int CMP_W = 17;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_SLOT      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOTS_IN_USE   = 3'd0,
    REG_FIRST_BASE     = 3'd1,
    REG_SECOND_BASE    = 3'd2,
    REG_SLOT_STRIDE    = 3'd3,
    REG_SECOND_ENABLED = 3'd4
  } cfg_reg_t;

  // Configuration register set
  typedef struct packed {
    logic [COUNT_W-1:0]  slots_in_use;
    logic [ADDR_W-1:0]   first_base_address;
    logic [ADDR_W-1:0]   second_base_address;
    logic [STRIDE_W-1:0] slot_stride;
    logic                second_enabled;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_MULT,
    S_LOAD
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic fetch;
    logic mult;
    logic load;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic out_room;
  } dp_sts_t;

endpackage

@@ src/bsa_if.sv @@
`timescale 1ns / 1ps

// Request channel: operation and slot to release
interface bsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::OP_W-1:0]    op;
  logic [bsa_pkg::SLOT_W-1:0]  free_slot;

  modport source (output valid, output op, output free_slot, input ready);
  modport sink   (input valid, input op, input free_slot, output ready);
endinterface

// Response channel: status, slot and the two addresses
interface bsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::STATUS_W-1:0]  status;
  logic [bsa_pkg::SLOT_W-1:0]    slot_number;
  logic [bsa_pkg::ADDR_W-1:0]    first_address;
  logic [bsa_pkg::ADDR_W-1:0]    second_address;

  modport source (output valid, output status, output slot_number,
                  output first_address, output second_address, input ready);
  modport sink   (input valid, input status, input slot_number,
                  input first_address, input second_address, output ready);
endinterface

@@ src/bitmap_slot_allocator_unit.sv @@
`timescale 1ns / 1ps

// First-fit slot allocator over a free map of NUM_SLOTS bits held as rows of GROUP_BITS.
// After reset the block runs a clearing pass over all ceil(NUM_SLOTS / GROUP_BITS) rows with
// ready low; configuration writes are taken during it. Each transaction then takes four
// steps from accept to result: one to pick the lowest nonempty row from the summary bits
// and read it, one to priority-encode and write the row back, one for the index times
// stride multiply, and one to load the output register. The controller walks these four
// steps for one transaction at a time, so a new transaction is accepted only after the last
// one has loaded its result; a result waiting in the output register does not block
// the next accept, but holds that transaction at its load step until the result is taken.

module bitmap_slot_allocator_unit #(
  parameter int NUM_SLOTS  = 1024,
  parameter int GROUP_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bsa_req_if.sink                            req_ch,
  bsa_rsp_if.source                          rsp_ch
);

  bsa_pkg::cfg_t     cfg;
  bsa_pkg::ctl_cmd_t cmd;
  bsa_pkg::dp_sts_t  sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slots_in_use        <= bsa_pkg::COUNT_W'(1024);
      cfg.first_base_address  <= '0;
      cfg.second_base_address <= '0;
      cfg.slot_stride         <= bsa_pkg::STRIDE_W'(32);
      cfg.second_enabled      <= 1'b0;
    end else if (cfg_we) begin
      unique case (bsa_pkg::cfg_reg_t'(cfg_index))
        bsa_pkg::REG_SLOTS_IN_USE:
          cfg.slots_in_use <= cfg_wdata[bsa_pkg::COUNT_W-1:0];
        bsa_pkg::REG_FIRST_BASE:
          cfg.first_base_address <= cfg_wdata;
        bsa_pkg::REG_SECOND_BASE:
          cfg.second_base_address <= cfg_wdata;
        bsa_pkg::REG_SLOT_STRIDE:
          cfg.slot_stride <= cfg_wdata[bsa_pkg::STRIDE_W-1:0];
        bsa_pkg::REG_SECOND_ENABLED:
          cfg.second_enabled <= cfg_wdata[0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .GROUP_BITS (GROUP_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .op             (req_ch.op),
    .free_slot      (req_ch.free_slot),
    .out_valid      (rsp_ch.valid),
    .out_ready      (rsp_ch.ready),
    .status         (rsp_ch.status),
    .slot_number    (rsp_ch.slot_number),
    .first_address  (rsp_ch.first_address),
    .second_address (rsp_ch.second_address)
  );

endmodule

@@ src/bsa_ctrl.sv @@
`timescale 1ns / 1ps

module bsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bsa_pkg::dp_sts_t  sts,
  output bsa_pkg::ctl_cmd_t cmd
);

  bsa_pkg::ctl_state_t state;
  bsa_pkg::ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bsa_pkg::S_CLEAR: begin
        if (sts.clear_done) state_next = bsa_pkg::S_IDLE;
      end
      bsa_pkg::S_IDLE: begin
        if (req_valid) state_next = bsa_pkg::S_FETCH;
      end
      bsa_pkg::S_FETCH: begin
        state_next = bsa_pkg::S_MULT;
      end
      bsa_pkg::S_MULT: begin
        state_next = bsa_pkg::S_LOAD;
      end
      bsa_pkg::S_LOAD: begin
        if (sts.out_room) state_next = bsa_pkg::S_IDLE;
      end
      default: begin
        state_next = bsa_pkg::S_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      bsa_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      bsa_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      bsa_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      bsa_pkg::S_MULT: begin
        cmd.mult = 1'b1;
      end
      bsa_pkg::S_LOAD: begin
        cmd.load = sts.out_room;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/bsa_datapath.sv @@
`timescale 1ns / 1ps

module bsa_datapath #(
  parameter int NUM_SLOTS  = 1024,
  parameter int GROUP_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bsa_pkg::ctl_cmd_t              cmd,
  output bsa_pkg::dp_sts_t               sts,
  input  bsa_pkg::cfg_t                  cfg,
  input  logic [bsa_pkg::OP_W-1:0]       op,
  input  logic [bsa_pkg::SLOT_W-1:0]     free_slot,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bsa_pkg::STATUS_W-1:0]   status,
  output logic [bsa_pkg::SLOT_W-1:0]     slot_number,
  output logic [bsa_pkg::ADDR_W-1:0]     first_address,
  output logic [bsa_pkg::ADDR_W-1:0]     second_address
);

  localparam int NUM_GROUPS = (NUM_SLOTS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int RW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BW         = $clog2(GROUP_BITS);
  localparam int IW         = $clog2(NUM_SLOTS);
  localparam int LAST_VALID = NUM_SLOTS - (NUM_GROUPS - 1) * GROUP_BITS;
  localparam logic [RW-1:0] LAST_ROW = RW'(NUM_GROUPS - 1);
  localparam int CW         = bsa_pkg::CMP_W;

  // Reciprocal for splitting a 10-bit slot into row and bit
  localparam int DIV_SH = 20;
  localparam int RECIP  = ((1 << DIV_SH) + GROUP_BITS - 1) / GROUP_BITS;
  localparam int PW     = bsa_pkg::SLOT_W + DIV_SH;

  // Free map words and per-row nonempty summary
  logic [GROUP_BITS-1:0] mem [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] nonempty;
  logic [GROUP_BITS-1:0] rdata;

  logic [RW-1:0]         clr_row;
  logic [GROUP_BITS-1:0] fill;

  logic [bsa_pkg::OP_W-1:0]   op_q;
  logic [RW-1:0]              grp_q;
  logic [BW-1:0]              bit_q;
  logic                       any_q;
  logic                       req_ok_q;
  bsa_pkg::status_t           status_q;
  logic                       ok_q;
  logic [IW-1:0]              idx_q;
  logic [31:0]                prod_q;

  logic [RW-1:0]         first_grp;
  logic                  grp_found;
  logic [PW-1:0]         row_prod;
  logic [bsa_pkg::SLOT_W-1:0] req_row;
  logic [bsa_pkg::SLOT_W-1:0] row_base;
  logic                  req_ok;

  logic [BW-1:0]         low_bit;
  logic [CW-1:0]         alloc_idx;
  logic                  alloc_ok;
  logic [GROUP_BITS-1:0] alloc_mask;
  logic [GROUP_BITS-1:0] free_mask;
  logic [GROUP_BITS-1:0] alloc_word;

  logic                  mem_we;
  logic [RW-1:0]         mem_waddr;
  logic [GROUP_BITS-1:0] mem_wdata;
  logic                  sum_we;
  logic                  sum_val;

  // Lowest row that still holds a free slot
  always_comb begin
    first_grp = '0;
    grp_found = 1'b0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        first_grp = RW'(i);
        grp_found = 1'b1;
      end
    end
  end

  // Split the slot to release into row and bit
  assign row_prod = PW'(free_slot) * PW'(RECIP);
  assign req_row  = row_prod[PW-1:DIV_SH];
  assign row_base = bsa_pkg::SLOT_W'(req_row * bsa_pkg::SLOT_W'(GROUP_BITS));
  assign req_ok   = (CW'(free_slot) < CW'(cfg.slots_in_use)) &&
                    (CW'(free_slot) < CW'(NUM_SLOTS));

  // Capture the request and read its row
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op;
      any_q    <= grp_found;
      req_ok_q <= req_ok;
      bit_q    <= BW'(free_slot - row_base);
      grp_q    <= (op == bsa_pkg::OP_FREE) ? RW'(req_row) : first_grp;
      rdata    <= (op == bsa_pkg::OP_FREE) ? mem[RW'(req_row)] : mem[first_grp];
    end
  end

  // Lowest free bit of the fetched word
  always_comb begin
    low_bit = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (rdata[i]) low_bit = BW'(i);
    end
  end

  assign alloc_idx  = CW'(grp_q) * CW'(GROUP_BITS) + CW'(low_bit);
  assign alloc_ok   = any_q && (alloc_idx < CW'(cfg.slots_in_use));
  assign alloc_mask = GROUP_BITS'(1) << low_bit;
  assign free_mask  = GROUP_BITS'(1) << bit_q;
  assign alloc_word = rdata & ~alloc_mask;

  // Fill pattern for the clearing pass; bits past the last slot stay used
  always_comb begin
    for (int i = 0; i < GROUP_BITS; i++) begin
      fill[i] = (clr_row != LAST_ROW) || (i < LAST_VALID);
    end
  end

  // Map write port: clearing pass, then read-modify-write of one row
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = grp_q;
    mem_wdata = rdata;
    sum_we    = 1'b0;
    sum_val   = 1'b0;
    priority if (cmd.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = fill;
    end else if (cmd.fetch && op_q == bsa_pkg::OP_ALLOC && alloc_ok) begin
      mem_we    = 1'b1;
      mem_wdata = alloc_word;
      sum_we    = 1'b1;
      sum_val   = |alloc_word;
    end else if (cmd.fetch && op_q == bsa_pkg::OP_FREE && req_ok_q) begin
      mem_we    = 1'b1;
      mem_wdata = rdata | free_mask;
      sum_we    = 1'b1;
      sum_val   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // Summary bits and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '1;
      clr_row  <= '0;
    end else begin
      if (sum_we) nonempty[mem_waddr] <= sum_val;
      if (cmd.clear_wr) clr_row <= clr_row + RW'(1);
    end
  end

  assign sts.clear_done = (clr_row == LAST_ROW);
  assign sts.out_room   = !out_valid || out_ready;

  // Record the outcome of the row update
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      if (op_q == bsa_pkg::OP_ALLOC) begin
        status_q <= alloc_ok ? bsa_pkg::ST_OK : bsa_pkg::ST_NO_SLOT;
        ok_q     <= alloc_ok;
        idx_q    <= IW'(alloc_idx);
      end else begin
        status_q <= req_ok_q ? bsa_pkg::ST_OK : bsa_pkg::ST_OUT_OF_RANGE;
        ok_q     <= 1'b0;
        idx_q    <= '0;
      end
    end
  end

  // Slot offset
  always_ff @(posedge clk) begin
    if (cmd.mult) prod_q <= 32'(idx_q) * 32'(cfg.slot_stride);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= status_q;
      slot_number    <= ok_q ? bsa_pkg::SLOT_W'(idx_q) : '0;
      first_address  <= ok_q ? cfg.first_base_address + 64'(prod_q) : '0;
      second_address <= (ok_q && cfg.second_enabled) ?
                        cfg.second_base_address + 64'(prod_q) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A granted slot lies below the configured and built counts
  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load && ok_q |-> (CW'(idx_q) < CW'(cfg.slots_in_use)) &&
                         (CW'(idx_q) < CW'(NUM_SLOTS)))
    else $error("granted slot out of range");

  // The summary never marks a row nonempty whose word is all used
  a_summary_match: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch && op_q == bsa_pkg::OP_ALLOC && any_q |-> rdata != '0)
    else $error("summary bit set for a full row");

  // The output register is never overwritten while it still holds a result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid || out_ready)
    else $error("result overwritten");

  // Row updates stay inside the map
  a_row_in_map: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_waddr <= LAST_ROW)
    else $error("map write past last row");

endmodule
